@@ hdl/lcg_pkg.sv @@
// Package for the LCG random number unit: widths, mode codes, command
// and status structs shared by controller and datapath. No dependencies.
`default_nettype none
package lcg_pkg;
    localparam int SEED_BITS_DEF = 48;
    localparam int CFG_BITS = 48;
    localparam int MAX_TRIES = 16;
    localparam int TRY_BITS = 5;
    localparam logic [CFG_BITS-1:0] MULT_RESET = 48'd25214903917;
    localparam logic [CFG_BITS-1:0] INCR_RESET = 48'd11;
    localparam logic [0:0] REG_MULT = 1'b0;
    localparam logic [0:0] REG_INCR = 1'b1;

    localparam logic [3:0] MODE_LOAD  = 4'd0;
    localparam logic [3:0] MODE_U32   = 4'd1;
    localparam logic [3:0] MODE_U64   = 4'd2;
    localparam logic [3:0] MODE_I31   = 4'd3;
    localparam logic [3:0] MODE_I63   = 4'd4;
    localparam logic [3:0] MODE_R32   = 4'd5;
    localparam logic [3:0] MODE_R64   = 4'd6;
    localparam logic [3:0] MODE_Q23   = 4'd7;
    localparam logic [3:0] MODE_Q52   = 4'd8;
    localparam logic [3:0] MODE_S32   = 4'd9;
    localparam logic [3:0] MODE_S64   = 4'd10;

    // Datapath commands from the controller.
    typedef struct packed {
        logic capture;    // latch request fields, set seed/temp source
        logic step;       // run one LCG step on the working seed
        logic take_hi;    // put drawn word into high half of draw
        logic take_lo;    // put drawn word into low half of draw
        logic div_start;  // start the modulo unit (limit and remainder)
        logic finish;     // form result into output register
        logic commit;     // write working seed back to generator seed
    } lcg_cmd_t;

    typedef struct packed {
        logic step_done;
        logic div_done;
        logic is_pow2;
        logic trivial;
        logic accept_draw;
    } lcg_stat_t;
endpackage
`default_nettype wire

@@ hdl/lcg_random_number_unit.sv @@
// Top level of the LCG random number unit: controller plus datapath.
// Depends on lcg_pkg, lcg_ctrl and lcg_dpath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  request  | in_valid / in_stall  | mode, seed_or_min, upper_limit
//  result   | out_valid/ out_stall | value
//  config   | cfg_write            | cfg_index, cfg_data
//
// One LCG step runs in the shared 32x24 multiplier (four partial
// products, then write back). Load, unused modes and empty or unit
// ranges skip the LCG step.
// Range draws with a span that is not a power of two add two passes
// of the bit-serial modulo unit and one check per draw, up to 16 draws.
// Reset clears the seed to zero and loads the default multiplier and
// increment. A stalled result holds; the next request waits until it
// leaves the output register.
`default_nettype none
module lcg_random_number_unit
#(
    parameter int SEED_BITS = lcg_pkg::SEED_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [lcg_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  mode,
    input  wire logic [63:0] seed_or_min,
    input  wire logic [63:0] upper_limit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value
);
    import lcg_pkg::*;

    lcg_cmd_t  cmd;
    lcg_stat_t stat;

    // Sequence each transaction.
    lcg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold seed, step, draws and the modulo unit.
    lcg_dpath #(.SEED_BITS(SEED_BITS)) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .seed_or_min (seed_or_min),
        .upper_limit (upper_limit),
        .cmd         (cmd),
        .stat        (stat),
        .value       (value)
    );
endmodule
`default_nettype wire

@@ hdl/lcg_ctrl.sv @@
// Controller state machine for the LCG unit.
// Depends on lcg_pkg; drives lcg_cmd_t, reads lcg_stat_t.
`default_nettype none
module lcg_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [3:0]      mode,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  lcg_pkg::lcg_stat_t   stat,
    output lcg_pkg::lcg_cmd_t    cmd
);
    import lcg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_LIM   = 7'b0000100,
        ST_STEP  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_MOD   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] mode_reg, mode_next;
    logic [TRY_BITS-1:0] tries_reg, tries_next;
    logic word_reg, word_next;   // 1: the low word is being drawn
    logic out_valid_reg, out_valid_next;
    logic is_range, two_words, uses_step, mode_ok;

    always_comb
    begin
        is_range  = (mode_reg == MODE_R32) || (mode_reg == MODE_R64);
        two_words = (mode_reg == MODE_U64) || (mode_reg == MODE_I63) ||
                    (mode_reg == MODE_R64) || (mode_reg == MODE_Q52) ||
                    (mode_reg == MODE_S64);
        mode_ok   = (mode_reg <= MODE_S64);
        uses_step = mode_ok && (mode_reg != MODE_LOAD);
    end

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        tries_next     = tries_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.capture = 1'b1;
                    mode_next   = mode;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                tries_next = '0;
                word_next  = 1'b0;
                if (!uses_step)
                begin
                    state_next = ST_DONE;
                end
                else if (is_range && stat.trivial)
                begin
                    state_next = ST_DONE;
                end
                else if (is_range && !stat.is_pow2)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_LIM;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_LIM:
            begin
                if (stat.div_done)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (stat.step_done)
                begin
                    if (two_words && !word_reg)
                    begin
                        cmd.take_hi = 1'b1;
                        cmd.step    = 1'b1;
                        word_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.take_lo = 1'b1;
                        state_next  = (is_range && !stat.is_pow2) ? ST_CHECK : ST_DONE;
                    end
                end
            end
            ST_CHECK:
            begin
                tries_next = tries_reg + 1'b1;
                word_next  = 1'b0;
                if (stat.accept_draw || (tries_reg == TRY_BITS'(MAX_TRIES - 1)))
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_MOD:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    cmd.commit     = (mode_reg != MODE_S32) && (mode_reg != MODE_S64);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LOAD;
            tries_reg     <= '0;
            word_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tries_reg     <= tries_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_tries: assert property (@(posedge clk) disable iff (!rst_n)
        tries_reg <= TRY_BITS'(MAX_TRIES))
        else $error("retry count overran");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
endmodule
`default_nettype wire

@@ hdl/lcg_dpath.sv @@
// Datapath for the LCG unit: seed, split 48x64 multiplier, 64-bit modulo unit.
// Depends on lcg_pkg; driven by lcg_cmd_t from lcg_ctrl.
`default_nettype none
module lcg_dpath
#(
    parameter int SEED_BITS = lcg_pkg::SEED_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [lcg_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic [3:0]              mode,
    input  wire logic [63:0]             seed_or_min,
    input  wire logic [63:0]             upper_limit,
    input  lcg_pkg::lcg_cmd_t            cmd,
    output lcg_pkg::lcg_stat_t           stat,
    output logic [63:0]                  value
);
    import lcg_pkg::*;

    localparam int SB = SEED_BITS;

    logic [CFG_BITS-1:0] mult_reg, incr_reg;
    logic [SB-1:0] gen_seed_reg, work_reg;
    logic [3:0] mode_reg;
    logic [63:0] min_reg, span_reg, draw_reg, value_reg;
    logic [63:0] limit_reg;
    logic lim_done_reg;
    logic [63:0] value_calc, rng_v;

    // LCG step: four 32x24 style partial products over successive cycles.
    logic [2:0]  ph_reg;
    logic        busy_reg;
    logic [SB-1:0] acc_reg;
    logic [31:0] a_part;
    logic [23:0] m_part;
    logic [55:0] prod;
    logic [SB-1:0] prod_sh, step_seed;
    logic [63:0] a_ext;
    logic [CFG_BITS-1:0] m_ext;
    logic [31:0] top_w;

    assign a_ext  = 64'(work_reg);
    assign m_ext  = mult_reg;
    assign a_part = ph_reg[1] ? a_ext[63:32] : a_ext[31:0];
    assign m_part = ph_reg[0] ? m_ext[47:24] : m_ext[23:0];
    assign prod   = 56'(a_part) * 56'(m_part);
    always_comb
    begin
        case (ph_reg[1:0])
            2'd0: prod_sh = SB'(prod);
            2'd1: prod_sh = SB'({8'd0, prod} << 24);
            2'd2: prod_sh = SB'({8'd0, prod} << 32);
            default: prod_sh = SB'({8'd0, prod} << 56);
        endcase
    end
    assign step_seed = acc_reg;
    // The word is taken in the cycle the step completes, from the new seed.
    assign top_w     = 32'(step_seed >> (SB - 32));

    // Span and trivial checks; the span is latched with the request.
    logic [63:0] span_calc, lo_ext, lo_in, hi_in;
    logic r32, r32_in;
    assign r32     = (mode_reg == MODE_R32);
    assign lo_ext  = r32 ? {32'd0, min_reg[31:0]} : min_reg;
    assign r32_in  = (mode == MODE_R32);
    assign lo_in   = r32_in ? {32'd0, seed_or_min[31:0]} : seed_or_min;
    assign hi_in   = r32_in ? {32'd0, upper_limit[31:0]} : upper_limit;
    assign span_calc = (hi_in <= lo_in) ? 64'd0 : (hi_in - lo_in);

    // Restoring divider: dividend / span_reg, one bit per cycle.
    logic [6:0]  div_cnt_reg;
    logic        div_busy_reg, div_done_reg, div_limit_reg;
    logic [63:0] rem_reg, quo_src_reg;
    logic [64:0] rem_sh;
    assign rem_sh = {rem_reg, quo_src_reg[63]};

    logic [63:0] ones;
    assign ones = r32 ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;

    always_comb
    begin
        stat.step_done   = busy_reg && (ph_reg == 3'd4);
        stat.div_done    = div_done_reg;
        stat.is_pow2     = ((span_reg & (span_reg - 64'd1)) == 64'd0);
        stat.trivial     = (span_reg == 64'd0) || (span_reg == 64'd1);
        stat.accept_draw = (draw_reg <= limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg     <= MULT_RESET;
            incr_reg     <= INCR_RESET;
            gen_seed_reg <= '0;
            busy_reg     <= 1'b0;
            ph_reg       <= '0;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_MULT)
                    mult_reg <= cfg_data;
                else
                    incr_reg <= cfg_data;
            end
            if (cmd.step)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (ph_reg == 3'd4)
                    busy_reg <= 1'b0;
                else
                    ph_reg <= ph_reg + 3'd1;
            end
            div_done_reg <= !cmd.div_start && div_busy_reg && (div_cnt_reg == 7'd63);
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg && (div_cnt_reg == 7'd63))
            begin
                div_busy_reg <= 1'b0;
            end
            if (cmd.commit)
                gen_seed_reg <= work_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            min_reg  <= seed_or_min;
            span_reg <= span_calc;
            if ((mode == MODE_S32) || (mode == MODE_S64) || (mode == MODE_LOAD))
                work_reg <= SB'(seed_or_min);
            else
                work_reg <= gen_seed_reg;
        end
        if (cmd.step)
            acc_reg <= SB'(incr_reg);
        else if (busy_reg && (ph_reg != 3'd4))
            acc_reg <= acc_reg + prod_sh;
        if (busy_reg && (ph_reg == 3'd4))
            work_reg <= step_seed;
        if (cmd.take_hi)
            draw_reg <= {top_w, 32'd0};
        if (cmd.take_lo)
        begin
            if (mode_reg == MODE_R32)
                draw_reg <= {32'd0, top_w};
            else if ((mode_reg == MODE_U64) || (mode_reg == MODE_I63) ||
                     (mode_reg == MODE_R64) || (mode_reg == MODE_Q52) ||
                     (mode_reg == MODE_S64))
                draw_reg <= {draw_reg[63:32], top_w};
            else
                draw_reg <= {32'd0, top_w};
        end
        // Modulo unit: first pass finds ones % span for the limit, the
        // second finds draw % span.
        if (cmd.div_start)
        begin
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            div_limit_reg <= !lim_done_reg;
            quo_src_reg   <= lim_done_reg ? draw_reg : ones;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 7'd1;
            quo_src_reg <= quo_src_reg << 1;
            if (rem_sh >= {1'b0, span_reg})
                rem_reg <= 64'(rem_sh - {1'b0, span_reg});
            else
                rem_reg <= rem_sh[63:0];
        end
        if (div_done_reg && div_limit_reg)
            limit_reg <= ones - rem_reg;
        if (cmd.finish)
            value_reg <= value_calc;
    end

    // The limit pass runs first; track which pass is next.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            lim_done_reg <= 1'b0;
        else if (div_done_reg && div_limit_reg)
            lim_done_reg <= 1'b1;
    end

    always_comb
    begin
        if (stat.trivial)
            rng_v = lo_ext;
        else if (stat.is_pow2)
            rng_v = (draw_reg & (span_reg - 64'd1)) + lo_ext;
        else
            rng_v = rem_reg + lo_ext;
        case (mode_reg)
            MODE_U32, MODE_U64, MODE_S32, MODE_S64: value_calc = draw_reg;
            MODE_I31: value_calc = {33'd0, draw_reg[30:0]};
            MODE_I63: value_calc = {1'b0, draw_reg[62:0]};
            MODE_R32: value_calc = {32'd0, rng_v[31:0]};
            MODE_R64: value_calc = rng_v;
            MODE_Q23: value_calc = {41'd0, draw_reg[31:9]};
            MODE_Q52: value_calc = {12'd0, draw_reg[63:12]};
            default:  value_calc = 64'd0;
        endcase
    end
    assign value = value_reg;

    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg)
        else $error("modulo unit did not start");
    a_step_div: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && div_busy_reg))
        else $error("multiplier and divider overlap");
    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.commit) && !$past(cfg_write) |-> $stable(gen_seed_reg) || $past(busy_reg))
        else $error("seed changed without commit");
endmodule
`default_nettype wire
